>>> src/plc_pkg.sv
// Package for the positional list block: field widths, operation codes,
// cell commands and the command bundle broadcast to every cell.
// No dependencies.
package plc_pkg;

   localparam int POS_W      = 9;
   localparam int VALUE_W    = 32;
   localparam int INDEX_W    = 8;
   localparam int COUNT_W    = 9;
   localparam int GROUP_SIZE = 16;
   localparam int GROUP_W    = 4;

   typedef enum logic [1:0] {
      OP_INSERT = 2'd0,
      OP_DELETE = 2'd1,
      OP_SEARCH = 2'd2
   } op_type;

   typedef enum logic [1:0] {
      CELL_HOLD,
      CELL_INSERT,
      CELL_DELETE,
      CELL_COMPARE
   } cell_op_type;

   typedef struct packed {
      cell_op_type        op;
      logic [POS_W-1:0]   pos;
      logic [VALUE_W-1:0] value;
   } cell_cmd_type;

endpackage

>>> src/positional_list_insert_delete_search.sv
// Positional list of signed 32-bit values held in a chain of CAPACITY cells.
// Insert and delete shift the cells at and above the position together; search
// compares all cells at once, then finds the first match in two registered steps
// (16-cell groups, then across groups). One operation is in flight at a time; a
// search adds group and select states between the execute and done states.
// A result may wait in the output register while the next request is taken.
// Depends on plc_pkg, plc_cell and plc_group_enc.
module positional_list_insert_delete_search import plc_pkg::*; #(
   parameter int CAPACITY = 256
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [47:0] req_tdata,  // position [8:0], value [40:9], zero [47:41]
   input  logic [1:0]  req_tuser,  // operation [1:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,  // found_index [7:0], list_count [16:8], zero [23:17]
   output logic        rsp_tuser   // success [0]
);

   localparam int CW         = $clog2(CAPACITY + 1);
   localparam int CMPW       = (CW > POS_W) ? CW : POS_W;
   localparam int NUM_GROUPS = (CAPACITY + GROUP_SIZE - 1) / GROUP_SIZE;
   localparam int HIT_W      = NUM_GROUPS * GROUP_SIZE;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EXEC,
      ST_GROUP,
      ST_SELECT,
      ST_DONE
   } state_type;

   state_type          state_ff, state_in;
   logic [1:0]         op_ff, op_in;
   logic [POS_W-1:0]   pos_ff, pos_in;
   logic [VALUE_W-1:0] value_ff, value_in;
   logic [CW-1:0]      count_ff, count_in;
   logic               res_success_ff, res_success_in;
   logic [INDEX_W-1:0] res_index_ff, res_index_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic               rsp_success_ff, rsp_success_in;
   logic [INDEX_W-1:0] rsp_index_ff, rsp_index_in;
   logic [COUNT_W-1:0] rsp_count_ff, rsp_count_in;

   cell_cmd_type       cmd;
   logic [VALUE_W-1:0] cell_data [CAPACITY];
   logic [HIT_W-1:0]   hit_vec;
   logic               grp_hit [NUM_GROUPS];
   logic [GROUP_W-1:0] grp_idx [NUM_GROUPS];

   logic               req_xfer, rsp_xfer, out_free;
   logic [CMPW-1:0]    pos_ext, cnt_ext;
   logic               ins_ok, del_ok, any_hit;
   logic [31:0]        sel_idx;

   assign req_xfer = req_tvalid && req_tready;
   assign rsp_xfer = rsp_valid_ff && rsp_tready;
   assign out_free = !rsp_valid_ff || rsp_tready;

   assign pos_ext = CMPW'(pos_ff);
   assign cnt_ext = CMPW'(count_ff);
   assign ins_ok  = (pos_ext <= cnt_ext) && (cnt_ext < CMPW'(CAPACITY));
   assign del_ok  = pos_ext < cnt_ext;

   always_comb begin
      cmd.op    = CELL_HOLD;
      cmd.pos   = pos_ff;
      cmd.value = value_ff;
      if (state_ff == ST_EXEC) begin
         case (op_ff)
            OP_INSERT: cmd.op = ins_ok ? CELL_INSERT : CELL_HOLD;
            OP_DELETE: cmd.op = del_ok ? CELL_DELETE : CELL_HOLD;
            OP_SEARCH: cmd.op = CELL_COMPARE;
            default:   cmd.op = CELL_HOLD;
         endcase
      end
   end

   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      plc_cell #(
         .INDEX (i),
         .CW    (CW)
      ) u_cell (
         .clock      (clock),
         .cmd        (cmd),
         .count      (count_ff),
         .left_data  (cell_data[(i > 0) ? i - 1 : 0]),
         .right_data (cell_data[(i < CAPACITY - 1) ? i + 1 : CAPACITY - 1]),
         .data       (cell_data[i]),
         .match      (hit_vec[i])
      );
   end

   if (HIT_W > CAPACITY) begin : g_pad
      assign hit_vec[HIT_W-1:CAPACITY] = '0;
   end

   for (genvar g = 0; g < NUM_GROUPS; g++) begin : g_group
      plc_group_enc u_group_enc (
         .clock (clock),
         .hits  (hit_vec[g*GROUP_SIZE +: GROUP_SIZE]),
         .hit   (grp_hit[g]),
         .idx   (grp_idx[g])
      );
   end

   always_comb begin
      any_hit = 1'b0;
      sel_idx = '0;
      for (int g = NUM_GROUPS - 1; g >= 0; g--) begin
         if (grp_hit[g]) begin
            any_hit = 1'b1;
            sel_idx = (32'(g) << GROUP_W) | 32'(grp_idx[g]);
         end
      end
   end

   always_comb begin
      state_in       = state_ff;
      op_in          = op_ff;
      pos_in         = pos_ff;
      value_in       = value_ff;
      count_in       = count_ff;
      res_success_in = res_success_ff;
      res_index_in   = res_index_ff;
      rsp_valid_in   = rsp_xfer ? 1'b0 : rsp_valid_ff;
      rsp_success_in = rsp_success_ff;
      rsp_index_in   = rsp_index_ff;
      rsp_count_in   = rsp_count_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_xfer) begin
               op_in    = req_tuser;
               pos_in   = req_tdata[POS_W-1:0];
               value_in = req_tdata[POS_W +: VALUE_W];
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            res_index_in   = '0;
            res_success_in = 1'b0;
            state_in       = ST_DONE;
            case (op_ff)
               OP_INSERT: begin
                  res_success_in = ins_ok;
                  if (ins_ok) begin
                     count_in = count_ff + CW'(1);
                  end
               end
               OP_DELETE: begin
                  res_success_in = del_ok;
                  if (del_ok) begin
                     count_in = count_ff - CW'(1);
                  end
               end
               OP_SEARCH: state_in = ST_GROUP;
               default: begin
               end
            endcase
         end
         ST_GROUP: begin
            state_in = ST_SELECT;
         end
         ST_SELECT: begin
            res_success_in = any_hit;
            res_index_in   = sel_idx[INDEX_W-1:0];
            state_in       = ST_DONE;
         end
         ST_DONE: begin
            if (out_free) begin
               rsp_valid_in   = 1'b1;
               rsp_success_in = res_success_ff;
               rsp_index_in   = res_index_ff;
               rsp_count_in   = COUNT_W'(count_ff);
               state_in       = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      op_ff          <= op_in;
      pos_ff         <= pos_in;
      value_ff       <= value_in;
      res_success_ff <= res_success_in;
      res_index_ff   <= res_index_in;
      rsp_success_ff <= rsp_success_in;
      rsp_index_ff   <= rsp_index_in;
      rsp_count_ff   <= rsp_count_in;
   end

   assign req_tready = state_ff == ST_IDLE;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {7'b0, rsp_count_ff, rsp_index_ff};
   assign rsp_tuser  = rsp_success_ff;

endmodule

>>> src/plc_cell.sv
// One list cell: holds a single entry, shifts from its neighbors on
// insert/delete and registers an equality match on search.
// Depends on plc_pkg.
module plc_cell import plc_pkg::*; #(
   parameter int INDEX = 0,
   parameter int CW    = 9
) (
   input  logic               clock,
   input  cell_cmd_type       cmd,
   input  logic [CW-1:0]      count,
   input  logic [VALUE_W-1:0] left_data,
   input  logic [VALUE_W-1:0] right_data,
   output logic [VALUE_W-1:0] data,
   output logic               match
);

   logic [VALUE_W-1:0] data_ff, data_in;
   logic               match_ff, match_in;
   logic               at_pos, above_pos, in_list;

   assign at_pos    = 32'(INDEX) == 32'(cmd.pos);
   assign above_pos = 32'(INDEX) > 32'(cmd.pos);
   assign in_list   = 32'(INDEX) < 32'(count);

   always_comb begin
      data_in  = data_ff;
      match_in = match_ff;
      case (cmd.op)
         CELL_INSERT: begin
            if (at_pos) begin
               data_in = cmd.value;
            end else if (above_pos) begin
               data_in = left_data;
            end
         end
         CELL_DELETE: begin
            if (at_pos || above_pos) begin
               data_in = right_data;
            end
         end
         CELL_COMPARE: begin
            match_in = in_list && (data_ff == cmd.value);
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      data_ff  <= data_in;
      match_ff <= match_in;
   end

   assign data  = data_ff;
   assign match = match_ff;

endmodule

>>> src/plc_group_enc.sv
// Find-first encoder over one group of cell match bits, registered.
// Depends on plc_pkg.
module plc_group_enc import plc_pkg::*; (
   input  logic                  clock,
   input  logic [GROUP_SIZE-1:0] hits,
   output logic                  hit,
   output logic [GROUP_W-1:0]    idx
);

   logic               hit_ff, hit_in;
   logic [GROUP_W-1:0] idx_ff, idx_in;

   always_comb begin
      hit_in = |hits;
      idx_in = '0;
      for (int i = GROUP_SIZE - 1; i >= 0; i--) begin
         if (hits[i]) begin
            idx_in = GROUP_W'(i);
         end
      end
   end

   always_ff @(posedge clock) begin
      hit_ff <= hit_in;
      idx_ff <= idx_in;
   end

   assign hit = hit_ff;
   assign idx = idx_ff;

endmodule
